>>> rtl/core/tis_pkg.sv
`default_nettype none

package tis_pkg;

    localparam int unsigned TS_W      = 64;
    localparam int unsigned IVL_W     = 32;
    localparam int unsigned DIV_CNT_W = $clog2(IVL_W);

    localparam logic [IVL_W-1:0] COUNT_MAX    = '1;
    localparam logic [IVL_W-1:0] JITTER_RESET = IVL_W'(2);

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/tis_div.sv
`default_nettype none

module tis_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [tis_pkg::IVL_W-1:0] dividend,
    input  wire logic [tis_pkg::IVL_W-1:0] divisor,
    output logic                           done,
    output logic      [tis_pkg::IVL_W-1:0] quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [tis_pkg::DIV_CNT_W-1:0] step_reg;
    logic [tis_pkg::IVL_W-1:0]     rem_reg;
    logic [tis_pkg::IVL_W-1:0]     quo_reg;
    logic [tis_pkg::IVL_W-1:0]     dsr_reg;

    logic [tis_pkg::IVL_W:0]       shifted;
    logic [tis_pkg::IVL_W:0]       trial;
    logic                          fits;

    // one restoring step per cycle while busy, dividend shifted out of quo_reg
    assign shifted = {rem_reg, quo_reg[tis_pkg::IVL_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = ~trial[tis_pkg::IVL_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == tis_pkg::DIV_CNT_W'(tis_pkg::IVL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[tis_pkg::IVL_W-1:0] : shifted[tis_pkg::IVL_W-1:0];
            quo_reg <= {quo_reg[tis_pkg::IVL_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a preceding busy step");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tis_ctrl.sv
`default_nettype none

module tis_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tis_pkg::sts_t sts,
    output tis_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_EVAL;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_EVAL: begin
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    state_reg <= sts.need_div ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    if (sts.div_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (sts.out_free) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready       = s_ready_reg;
    assign cmd.load      = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
    assign cmd.eval      = (state_reg == ST_EVAL);
    assign cmd.div_start = (state_reg == ST_PREP) && sts.need_div;
    assign cmd.commit    = (state_reg == ST_FIN) && sts.out_free;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tis_dp.sv
`default_nettype none

module tis_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire tis_pkg::cmd_t             cmd,
    output tis_pkg::sts_t                  sts,
    input  wire logic [tis_pkg::TS_W-1:0]  s_timestamp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [tis_pkg::IVL_W-1:0] cfg_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_updated,
    output logic      [tis_pkg::IVL_W-1:0] m_interval_count,
    output logic      [tis_pkg::IVL_W-1:0] m_mean_interval,
    output logic      [tis_pkg::IVL_W-1:0] m_min_interval,
    output logic      [tis_pkg::IVL_W-1:0] m_max_interval,
    output logic                           m_timing_ok
);

    localparam int unsigned W = tis_pkg::IVL_W;

    // statistics state
    logic [tis_pkg::TS_W-1:0] last_reg;
    logic [W-1:0]             count_reg;
    logic [W-1:0]             mean_reg;
    logic [W-1:0]             min_reg;
    logic [W-1:0]             max_reg;
    logic [W-1:0]             jitter_reg;

    // per-beat working registers
    logic [tis_pkg::TS_W-1:0] ts_reg;
    logic [W-1:0]             dt_reg;
    logic [W-1:0]             cnt_new_reg;
    logic                     upd_reg;
    logic                     zero_reg;
    logic                     neg_reg;

    // output register
    logic                     m_valid_reg;
    logic                     m_updated_reg;
    logic [W-1:0]             m_count_reg;
    logic [W-1:0]             m_mean_reg;
    logic [W-1:0]             m_min_reg;
    logic [W-1:0]             m_max_reg;
    logic                     m_ok_reg;

    logic                     ts_zero;
    logic                     ts_stale;
    logic [W-1:0]             dt;
    logic [W-1:0]             cnt_inc;
    logic                     first_ivl;
    logic [W:0]               diff;
    logic [W-1:0]             diff_mag;
    logic                     div_done;
    logic [W-1:0]             quotient;

    logic [W-1:0]             count_next;
    logic [W-1:0]             mean_next;
    logic [W-1:0]             min_next;
    logic [W-1:0]             max_next;
    logic [W-1:0]             spread;
    logic                     ok_next;

    assign ts_zero  = (ts_reg == '0);
    assign ts_stale = (last_reg == '0) || (ts_reg <= last_reg);
    assign dt       = ts_reg[W-1:0] - last_reg[W-1:0];
    assign cnt_inc  = (count_reg == tis_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;

    assign first_ivl = (cnt_new_reg == W'(1));
    assign diff      = {1'b0, dt_reg} - {1'b0, mean_reg};
    assign diff_mag  = diff[W] ? (~diff[W-1:0] + 1'b1) : diff[W-1:0];

    tis_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (diff_mag),
        .divisor  (cnt_new_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ts_reg <= s_timestamp;
        end
        if (cmd.eval) begin
            dt_reg      <= dt;
            cnt_new_reg <= cnt_inc;
            zero_reg    <= ts_zero;
            upd_reg     <= !ts_zero && !ts_stale && (dt != '0);
        end
        if (cmd.div_start) begin
            neg_reg <= diff[W];
        end
    end

    always_comb begin
        count_next = count_reg;
        mean_next  = mean_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (upd_reg) begin
            count_next = cnt_new_reg;
            if (first_ivl) begin
                mean_next = dt_reg;
                min_next  = dt_reg;
                max_next  = dt_reg;
            end else begin
                mean_next = neg_reg ? mean_reg - quotient : mean_reg + quotient;
                if ((min_reg == '0) || (dt_reg < min_reg)) begin
                    min_next = dt_reg;
                end
                if (dt_reg > max_reg) begin
                    max_next = dt_reg;
                end
            end
        end
        spread  = (max_next >= min_next) ? max_next - min_next : min_next - max_next;
        ok_next = (count_next != '0) && (spread <= jitter_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= '0;
            count_reg   <= '0;
            mean_reg    <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            jitter_reg  <= tis_pkg::JITTER_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                jitter_reg <= cfg_data;
            end
            if (cmd.commit) begin
                if (!zero_reg) begin
                    last_reg <= ts_reg;
                end
                count_reg   <= count_next;
                mean_reg    <= mean_next;
                min_reg     <= min_next;
                max_reg     <= max_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_updated_reg <= upd_reg;
            m_count_reg   <= count_next;
            m_mean_reg    <= mean_next;
            m_min_reg     <= min_next;
            m_max_reg     <= max_next;
            m_ok_reg      <= ok_next;
        end
    end

    assign sts.need_div = upd_reg && !first_ivl;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_updated        = m_updated_reg;
    assign m_interval_count = m_count_reg;
    assign m_mean_interval  = m_mean_reg;
    assign m_min_interval   = m_min_reg;
    assign m_max_interval   = m_max_reg;
    assign m_timing_ok      = m_ok_reg;

`ifndef SYNTHESIS
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_updated_reg) |-> (m_min_reg <= m_max_reg))
        else $error("min interval above max interval");
    a_upd_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_updated_reg) |-> (m_count_reg != '0))
        else $error("updated beat with zero count");
    a_ok_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ok_reg) |-> (m_count_reg != '0))
        else $error("timing_ok with zero count");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tick_interval_statistics.sv
// Interval statistics over a stream of 64-bit millisecond timestamps. Each
// input beat gives exactly one result beat carrying the count, running mean,
// minimum and maximum of the intervals seen so far, whether this beat added
// an interval, and timing_ok (count nonzero and max - min <= jitter_limit).
// Zero timestamps are ignored; the first, non-advancing or equal-low-word
// timestamps are stored without updating the statistics. One beat is in
// flight at a time: a beat that updates the mean after the first interval
// waits on the 32-step radix-2 divider for the mean correction; others skip
// it. A finished result waits in an output register, so the next beat can
// be taken before it is consumed. jitter_limit resets to 2; the user must
// write it through the cfg channel while idle; the block does not enforce it.
`default_nettype none

module tick_interval_statistics (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [tis_pkg::TS_W-1:0]  s_timestamp,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_updated,
    output logic      [tis_pkg::IVL_W-1:0] m_interval_count,
    output logic      [tis_pkg::IVL_W-1:0] m_mean_interval,
    output logic      [tis_pkg::IVL_W-1:0] m_min_interval,
    output logic      [tis_pkg::IVL_W-1:0] m_max_interval,
    output logic                           m_timing_ok,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [tis_pkg::IVL_W-1:0] cfg_data
);

    tis_pkg::cmd_t cmd;
    tis_pkg::sts_t sts;

    tis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tis_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_timestamp      (s_timestamp),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_updated        (m_updated),
        .m_interval_count (m_interval_count),
        .m_mean_interval  (m_mean_interval),
        .m_min_interval   (m_min_interval),
        .m_max_interval   (m_max_interval),
        .m_timing_ok      (m_timing_ok)
    );

endmodule

`default_nettype wire
